### sv/pnm_reader_block_padder_defines.svh
// Assertion macros used by the datapath module.
`ifndef PNM_READER_BLOCK_PADDER_DEFINES_SVH
`define PNM_READER_BLOCK_PADDER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PNM_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PNM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

### sv/pnm_pkg.sv
package pnm_pkg;
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_MAGIC    = 2'd0;
   localparam logic [1:0] ERR_TYPE     = 2'd1;
   localparam logic [1:0] ERR_ZERO     = 2'd2;
   localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_FIVE = 8'h35;
   localparam logic [7:0] CHAR_SIX  = 8'h36;

   // Command from the parser to the padding datapath.
   typedef struct packed {
      logic       start;
      logic [1:0] kind;
      logic [1:0] code;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] c3;
   } pnm_cmd_type;

   // Status from the padding datapath.
   typedef struct packed {
      logic busy;
      logic done;
   } pnm_stat_type;

   typedef logic [255:0][7:0] scale_table_type;

   // Quotient of 255 by each 8-bit value, found by counting multiples at
   // elaboration; entry zero is never read.
   function automatic scale_table_type build_scale_table();
      scale_table_type t;
      t = '0;
      for (int i = 1; i < 256; i++) begin
         for (int k = i; k < 256; k += i) t[i] = t[i] + 8'd1;
      end
      return t;
   endfunction

   localparam scale_table_type SCALE_TABLE = build_scale_table();

   // 255 / v for v in 1..255, by table.
   function automatic logic [7:0] scale_of(input logic [7:0] v);
      return SCALE_TABLE[v];
   endfunction
endpackage

### sv/pnm_reader_block_padder.sv
// PGM/PPM byte-stream reader with 8x8 block addressing and edge padding.
// The req channel takes one file byte per item, with req_new_file marking
// the first byte of a file. The rsp channel delivers header, error and pixel
// items; rsp_last marks the final item caused by one input byte.
// A byte that causes a result shows it in the cycle after it is accepted.
// Header bytes and samples that cause no burst are taken one per cycle while the receiver keeps up.
// A pixel on the last real column or row also writes its padding copies, one per
// cycle while the receiver takes them, up to 64 items; req_ready stays low while
// that sweep runs, and also in the cycle after the last pixel of an image is issued.
// When the receiver stalls, the output register holds its item and
// req_ready falls until the item is taken.
// Reset clears the parser to wait for a new file and drops any output item.
module pnm_reader_block_padder
   import pnm_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_new_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_error_code,
   output logic [8:0]  rsp_block_row,
   output logic [8:0]  rsp_block_col,
   output logic [5:0]  rsp_position,
   output logic [7:0]  rsp_comp_one,
   output logic [7:0]  rsp_comp_two,
   output logic [7:0]  rsp_comp_three,
   output logic        rsp_is_color,
   output logic [12:0] rsp_width_out,
   output logic [12:0] rsp_height_out,
   output logic        rsp_last
);
   pnm_cmd_type  cmd;
   pnm_stat_type stat;
   logic [12:0]  width_q, height_q;
   logic         color_q;

   pnm_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_in_byte, .req_new_file,
      .stat, .cmd, .width_q, .height_q, .color_q);

   pnm_dpath u_dpath (
      .clock, .reset, .cmd, .width_q, .height_q, .color_q, .stat,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_error_code, .rsp_block_row,
      .rsp_block_col, .rsp_position, .rsp_comp_one, .rsp_comp_two,
      .rsp_comp_three, .rsp_is_color, .rsp_width_out, .rsp_height_out, .rsp_last);
endmodule

### sv/pnm_ctrl.sv
module pnm_ctrl
   import pnm_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_in_byte,
   input  logic         req_new_file,
   input  pnm_stat_type stat,
   output pnm_cmd_type  cmd,
   output logic [12:0]  width_q,
   output logic [12:0]  height_q,
   output logic         color_q
);
   localparam logic [2:0] PH_IDLE = 3'd0, PH_MAGIC = 3'd1, PH_WIDTH = 3'd2,
      PH_HEIGHT = 3'd3, PH_MAXVAL = 3'd4, PH_PIXELS = 3'd5, PH_DONE = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic        comm_ff, comm_in, started_ff, started_in, ov_ff, ov_in;
   logic [15:0] acc_ff, acc_in;
   logic [12:0] w_ff, w_in, h_ff, h_in;
   logic [7:0]  scale_ff, scale_in;
   logic [1:0]  ci_ff, ci_in;
   logic [7:0]  held0_ff, held0_in, held1_ff, held1_in;
   logic        take;
   logic [7:0]  b;
   logic [19:0] prod;
   logic [15:0] num;
   logic [15:0] prod_s;
   logic [7:0]  sv8;

   assign req_ready = !stat.busy;
   assign take = req_valid && req_ready;
   assign b = req_in_byte;
   assign width_q = w_ff;
   assign height_q = h_ff;
   assign color_q = fmt_ff[0];

   // Parse one byte and decide what it emits.
   always_comb begin
      phase_in = phase_ff; fmt_in = fmt_ff; comm_in = comm_ff;
      started_in = started_ff; ov_in = ov_ff; acc_in = acc_ff;
      w_in = w_ff; h_in = h_ff; scale_in = scale_ff; ci_in = ci_ff;
      held0_in = held0_ff; held1_in = held1_ff;
      cmd = '0;
      prod = 20'({acc_ff, 3'b0}) + 20'({acc_ff, 1'b0}) + 20'(b - CHAR_ZERO);
      num = acc_ff;
      sv8 = 8'd0;
      prod_s = 16'd0;
      if (take) begin
         if (req_new_file) begin
            fmt_in = 2'd0; comm_in = 1'b0; started_in = 1'b0; ov_in = 1'b0;
            acc_in = '0; w_in = '0; h_in = '0; scale_in = '0; ci_in = '0;
            held0_in = '0; held1_in = '0;
            if (b != CHAR_P) begin
               cmd.start = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_MAGIC;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_MAGIC;
            end
         end else if (phase_ff == PH_MAGIC) begin
            phase_in = PH_WIDTH;
            unique case (b)
               CHAR_TWO:   fmt_in = 2'd0;
               CHAR_THREE: fmt_in = 2'd1;
               CHAR_FIVE:  fmt_in = 2'd2;
               CHAR_SIX:   fmt_in = 2'd3;
               default: begin
                  cmd.start = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_TYPE;
                  phase_in = PH_IDLE;
               end
            endcase
         end else if (phase_ff >= PH_WIDTH && phase_ff <= PH_PIXELS) begin
            if (comm_ff) begin
               if (b == CHAR_LF) comm_in = 1'b0;
            end else if (phase_ff == PH_PIXELS && fmt_ff[1]) begin
               prod_s = 16'(b * scale_ff);
               sv8 = prod_s[7:0];
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               started_in = 1'b1;
               if (prod > 20'hFFFF) begin
                  if (phase_ff == PH_PIXELS) acc_in = prod[15:0];
                  else begin ov_in = 1'b1; acc_in = 16'hFFFF; end
               end else acc_in = prod[15:0];
            end else begin
               if (b == CHAR_HASH) comm_in = 1'b1;
               if (started_ff) begin
                  acc_in = '0; ov_in = 1'b0; started_in = 1'b0;
                  prod_s = 16'(acc_ff[7:0] * scale_ff);
                  sv8 = prod_s[7:0];
               end
            end
            // Number finished in a header phase.
            if (!comm_ff && started_ff && !(phase_ff == PH_PIXELS)
                && !(b >= CHAR_ZERO && b <= CHAR_NINE)) begin
               if (num == 16'd0 && !ov_ff) begin
                  cmd.start = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_ZERO;
                  phase_in = PH_IDLE;
               end else begin
                  unique case (phase_ff)
                     PH_WIDTH: begin
                        if (ov_ff || 32'(num) > 32'(MAX_WIDTH)) begin
                           cmd.start = 1'b1; cmd.kind = KIND_ERROR;
                           cmd.code = ERR_TOO_BIG; phase_in = PH_IDLE;
                        end else begin
                           w_in = 13'(num); phase_in = PH_HEIGHT;
                        end
                     end
                     PH_HEIGHT: begin
                        if (ov_ff || 32'(num) > 32'(MAX_HEIGHT)) begin
                           cmd.start = 1'b1; cmd.kind = KIND_ERROR;
                           cmd.code = ERR_TOO_BIG; phase_in = PH_IDLE;
                        end else begin
                           h_in = 13'(num); phase_in = PH_MAXVAL;
                        end
                     end
                     default: begin
                        scale_in = (ov_ff || num > 16'd255) ? 8'd0 : scale_of(num[7:0]);
                        ci_in = '0; phase_in = PH_PIXELS;
                        cmd.start = 1'b1; cmd.kind = KIND_HEADER;
                     end
                  endcase
               end
            end
            // Sample finished in the pixel phase.
            if (!comm_ff && phase_ff == PH_PIXELS &&
                (fmt_ff[1] || (started_ff && !(b >= CHAR_ZERO && b <= CHAR_NINE)))) begin
               if (!fmt_ff[0]) begin
                  cmd.start = 1'b1; cmd.kind = KIND_PIXEL; cmd.c1 = sv8;
               end else if (ci_ff == 2'd0) begin
                  held0_in = sv8; ci_in = 2'd1;
               end else if (ci_ff == 2'd1) begin
                  held1_in = sv8; ci_in = 2'd2;
               end else begin
                  ci_in = 2'd0; cmd.start = 1'b1; cmd.kind = KIND_PIXEL;
                  cmd.c1 = held0_ff; cmd.c2 = held1_ff; cmd.c3 = sv8;
               end
            end
         end
      end
      if (stat.done) phase_in = PH_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; fmt_ff <= '0; comm_ff <= 1'b0; started_ff <= 1'b0;
         ov_ff <= 1'b0; acc_ff <= '0; w_ff <= '0; h_ff <= '0; scale_ff <= '0;
         ci_ff <= '0; held0_ff <= '0; held1_ff <= '0;
      end else begin
         phase_ff <= phase_in; fmt_ff <= fmt_in; comm_ff <= comm_in;
         started_ff <= started_in; ov_ff <= ov_in; acc_ff <= acc_in;
         w_ff <= w_in; h_ff <= h_in; scale_ff <= scale_in; ci_ff <= ci_in;
         held0_ff <= held0_in; held1_ff <= held1_in;
      end
   end
endmodule

### sv/pnm_dpath.sv
`include "pnm_reader_block_padder_defines.svh"

module pnm_dpath
   import pnm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pnm_cmd_type  cmd,
   input  logic [12:0]  width_q,
   input  logic [12:0]  height_q,
   input  logic         color_q,
   output pnm_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_kind,
   output logic [1:0]   rsp_error_code,
   output logic [8:0]   rsp_block_row,
   output logic [8:0]   rsp_block_col,
   output logic [5:0]   rsp_position,
   output logic [7:0]   rsp_comp_one,
   output logic [7:0]   rsp_comp_two,
   output logic [7:0]   rsp_comp_three,
   output logic         rsp_is_color,
   output logic [12:0]  rsp_width_out,
   output logic [12:0]  rsp_height_out,
   output logic         rsp_last
);
   // Current pixel position and the copy sweep.
   logic [11:0] r_ff, r_in, c_ff, c_in;
   logic [12:0] rr_ff, rr_in, cc_ff, cc_in, cend_ff, cend_in, rend_ff, rend_in;
   logic        act_ff, act_in, vld_ff, vld_in, done_ff, done_in;
   logic [1:0]  kind_ff, kind_in, code_ff, code_in;
   logic [7:0]  c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic        last_ff, last_in;
   logic        adv;
   logic [12:0] padw, padh, c1n, r1n;
   logic [12:0] cc_first;
   logic        rsp_stall;
   logic        kind_known;

   assign padw = (width_q + 13'd7) & ~13'd7;
   assign padh = (height_q + 13'd7) & ~13'd7;
   assign c1n = 13'(c_ff) + 13'd1;
   assign r1n = 13'(r_ff) + 13'd1;
   assign adv = !vld_ff || rsp_ready;
   // In the cycle after the last pixel is issued, done_ff keeps busy high and sends the parser to done.
   assign stat.busy = (vld_ff && !rsp_ready) || act_ff || done_ff;
   assign stat.done = done_ff;

   // First copy column of the pixel that is being padded.
   assign cc_first = (cend_ff == padw - 13'd1) ? width_q - 13'd1 : cend_ff;

   always_comb begin
      r_in = r_ff; c_in = c_ff; rr_in = rr_ff; cc_in = cc_ff;
      cend_in = cend_ff; rend_in = rend_ff; act_in = act_ff;
      vld_in = vld_ff && !rsp_ready; done_in = 1'b0;
      kind_in = kind_ff; code_in = code_ff; c1_in = c1_ff; c2_in = c2_ff;
      c3_in = c3_ff; last_in = last_ff;
      if (cmd.start && cmd.kind == KIND_HEADER) begin
         r_in = '0; c_in = '0;
      end
      if (cmd.start && adv) begin
         kind_in = cmd.kind; code_in = cmd.code; vld_in = 1'b1;
         c1_in = cmd.c1; c2_in = cmd.c2; c3_in = cmd.c3;
         rr_in = 13'(r_ff); cc_in = 13'(c_ff);
         if (cmd.kind == KIND_PIXEL) begin
            cend_in = (c1n == width_q) ? padw - 13'd1 : 13'(c_ff);
            rend_in = (r1n == height_q) ? padh - 13'd1 : 13'(r_ff);
            last_in = (cend_in == 13'(c_ff)) && (rend_in == 13'(r_ff));
            act_in = !last_in;
            // Step to the next real pixel.
            if (c1n >= width_q) begin
               c_in = '0; r_in = r_ff + 12'd1;
               if (r1n >= height_q) done_in = 1'b1;
            end else c_in = c_ff + 12'd1;
         end else begin
            last_in = 1'b1;
         end
      end else if (act_ff && adv) begin
         vld_in = 1'b1;
         if (cc_ff == cend_ff) begin
            cc_in = cc_first;
            rr_in = rr_ff + 13'd1;
         end else cc_in = cc_ff + 13'd1;
         last_in = (rr_in == rend_ff) && (cc_in == cend_ff);
         act_in = !last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0; act_ff <= 1'b0; done_ff <= 1'b0; r_ff <= '0; c_ff <= '0;
      end else begin
         vld_ff <= vld_in; act_ff <= act_in; done_ff <= done_in;
         r_ff <= r_in; c_ff <= c_in;
      end
      rr_ff <= rr_in; cc_ff <= cc_in; cend_ff <= cend_in; rend_ff <= rend_in;
      kind_ff <= kind_in; code_ff <= code_in; c1_ff <= c1_in; c2_ff <= c2_in;
      c3_ff <= c3_in; last_ff <= last_in;
   end

   wire pix = kind_ff == KIND_PIXEL;
   wire hdr = kind_ff == KIND_HEADER;
   assign rsp_valid = vld_ff;
   assign rsp_kind = kind_ff;
   assign rsp_error_code = kind_ff == KIND_ERROR ? code_ff : 2'd0;
   assign rsp_block_row = pix ? rr_ff[11:3] : 9'd0;
   assign rsp_block_col = pix ? cc_ff[11:3] : 9'd0;
   assign rsp_position = pix ? {rr_ff[2:0], cc_ff[2:0]} : 6'd0;
   assign rsp_comp_one = pix ? c1_ff : 8'd0;
   assign rsp_comp_two = pix ? c2_ff : 8'd0;
   assign rsp_comp_three = pix ? c3_ff : 8'd0;
   assign rsp_is_color = hdr ? color_q : 1'b0;
   assign rsp_width_out = hdr ? width_q : 13'd0;
   assign rsp_height_out = hdr ? height_q : 13'd0;
   assign rsp_last = last_ff;

   // Checks on the result channel and the padding sweep.
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign kind_known = (kind_ff == KIND_PIXEL) || (kind_ff == KIND_HEADER)
      || (kind_ff == KIND_ERROR);
   `PNM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(kind_ff) && $stable(rr_ff), "stalled item changed")
   `PNM_ASSERT_IMP(a_kind_known, clock, reset, rsp_valid, kind_known, "unknown item kind")
   `PNM_ASSERT_IMP(a_sweep_pixel, clock, reset, act_ff, pix, "sweep on a non-pixel item")
   `PNM_ASSERT_IMP(a_sweep_valid, clock, reset, act_ff, vld_ff, "sweep without an item")
endmodule

### tb/sv/pnm_reader_block_padder_test.sv
`timescale 1ns / 1ps

module pnm_reader_block_padder_test;
   import pnm_pkg::*;

   localparam int MAX_W = 4096;
   localparam int MAX_H = 4096;
   localparam int CYCLE_LIMIT = 2000000;

   // Parser phases of the predictor.
   typedef enum logic [3:0] {
      PH_IDLE, PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_file;
   } file_byte_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [8:0]  block_row;
      logic [8:0]  block_col;
      logic [5:0]  position;
      logic [7:0]  comp_one;
      logic [7:0]  comp_two;
      logic [7:0]  comp_three;
      logic        is_color;
      logic [12:0] width_out;
      logic [12:0] height_out;
      logic        last;
   } decoded_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_new_file;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_error_code;
   logic [8:0]  rsp_block_row;
   logic [8:0]  rsp_block_col;
   logic [5:0]  rsp_position;
   logic [7:0]  rsp_comp_one;
   logic [7:0]  rsp_comp_two;
   logic [7:0]  rsp_comp_three;
   logic        rsp_is_color;
   logic [12:0] rsp_width_out;
   logic [12:0] rsp_height_out;
   logic        rsp_last;

   pnm_reader_block_padder dut (.*);

   // Clock with a 4 ns period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Decoder state held by the predictor.
   phase_type   dec_phase;
   logic [1:0]  dec_format;
   logic        dec_comment;
   logic        dec_started;
   int unsigned dec_acc;
   logic        dec_ovf;
   int unsigned dec_width;
   int unsigned dec_height;
   int unsigned dec_scale;
   int unsigned dec_row;
   int unsigned dec_col;
   int unsigned dec_comp;
   logic [7:0]  dec_held [2];

   file_byte_type pending_bytes [$];
   decoded_type   expected_results [$];
   int          mismatch_count;
   int          byte_count;
   int          result_count;
   int          header_count;
   int          error_count;
   int          cycle_count;
   logic        long_hold;
   logic        req_taken;

   function automatic decoded_type blank_result();
      decoded_type r;
      r = '0;
      return r;
   endfunction

   function automatic void clear_decoder();
      dec_phase = PH_IDLE;
      dec_format = 2'd0;
      dec_comment = 1'b0;
      dec_started = 1'b0;
      dec_acc = 0;
      dec_ovf = 1'b0;
      dec_width = 0;
      dec_height = 0;
      dec_scale = 0;
      dec_row = 0;
      dec_col = 0;
      dec_comp = 0;
      dec_held[0] = 8'd0;
      dec_held[1] = 8'd0;
   endfunction

   function automatic void push_error(logic [1:0] code);
      decoded_type r;
      r = blank_result();
      r.kind = KIND_ERROR;
      r.error_code = code;
      r.last = 1'b1;
      expected_results.push_back(r);
      dec_phase = PH_IDLE;
   endfunction

   // One real pixel plus its padding copies, row-major over the copies.
   function automatic void push_pixel(logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
      int unsigned pad_w, pad_h, row_end, col_end;
      decoded_type r;
      pad_w = ((dec_width + 7) / 8) * 8;
      pad_h = ((dec_height + 7) / 8) * 8;
      row_end = (dec_row + 1 == dec_height) ? pad_h - 1 : dec_row;
      col_end = (dec_col + 1 == dec_width) ? pad_w - 1 : dec_col;
      for (int unsigned rr = dec_row; rr <= row_end; rr++) begin
         for (int unsigned cc = dec_col; cc <= col_end; cc++) begin
            r = blank_result();
            r.kind = KIND_PIXEL;
            r.block_row = 9'(rr / 8);
            r.block_col = 9'(cc / 8);
            r.position = 6'((rr % 8) * 8 + (cc % 8));
            r.comp_one = c1;
            r.comp_two = c2;
            r.comp_three = c3;
            r.last = (rr == row_end) && (cc == col_end);
            expected_results.push_back(r);
         end
      end
      dec_col++;
      if (dec_col >= dec_width) begin
         dec_col = 0;
         dec_row++;
         if (dec_row >= dec_height) dec_phase = PH_DONE;
      end
   endfunction

   function automatic void scale_sample(int unsigned s);
      logic [7:0] v;
      v = 8'(((s & 255) * dec_scale) & 255);
      if (!dec_format[0]) begin
         push_pixel(v, 8'd0, 8'd0);
      end else if (dec_comp < 2) begin
         dec_held[dec_comp] = v;
         dec_comp++;
      end else begin
         dec_comp = 0;
         push_pixel(dec_held[0], dec_held[1], v);
      end
   endfunction

   function automatic void end_number(int unsigned v, logic ovf);
      decoded_type r;
      case (dec_phase)
         PH_WIDTH, PH_HEIGHT: begin
            if (v == 0 && !ovf) push_error(ERR_ZERO);
            else if (ovf || v > ((dec_phase == PH_WIDTH) ? MAX_W : MAX_H))
               push_error(ERR_TOO_BIG);
            else if (dec_phase == PH_WIDTH) begin
               dec_width = v;
               dec_phase = PH_HEIGHT;
            end else begin
               dec_height = v;
               dec_phase = PH_MAXVAL;
            end
         end
         PH_MAXVAL: begin
            if (v == 0 && !ovf) begin
               push_error(ERR_ZERO);
            end else begin
               dec_scale = (ovf || v > 255) ? 0 : 255 / v;
               dec_row = 0;
               dec_col = 0;
               dec_comp = 0;
               dec_phase = PH_PIXELS;
               r = blank_result();
               r.kind = KIND_HEADER;
               r.is_color = dec_format[0];
               r.width_out = 13'(dec_width);
               r.height_out = 13'(dec_height);
               r.last = 1'b1;
               expected_results.push_back(r);
            end
         end
         default: scale_sample(v);
      endcase
   endfunction

   // Predicts the results of one accepted byte.
   function automatic void decode_byte(file_byte_type fb);
      logic [7:0] b;
      int unsigned v;
      logic ovf;
      b = fb.in_byte;
      if (fb.new_file) begin
         clear_decoder();
         if (b != CHAR_P) push_error(ERR_MAGIC);
         else dec_phase = PH_MAGIC;
         return;
      end
      if (dec_phase == PH_MAGIC) begin
         if (b == CHAR_TWO) dec_format = 2'd0;
         else if (b == CHAR_THREE) dec_format = 2'd1;
         else if (b == CHAR_FIVE) dec_format = 2'd2;
         else if (b == CHAR_SIX) dec_format = 2'd3;
         else begin
            push_error(ERR_TYPE);
            return;
         end
         dec_phase = PH_WIDTH;
         return;
      end
      if (!(dec_phase inside {PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS})) return;
      if (dec_comment) begin
         if (b == CHAR_LF) dec_comment = 1'b0;
         return;
      end
      if (dec_phase == PH_PIXELS && dec_format[1]) begin
         scale_sample(b);
         return;
      end
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         v = dec_acc * 10 + (b - CHAR_ZERO);
         if (v > 65535) begin
            if (dec_phase == PH_PIXELS) v = v & 65535;
            else begin
               dec_ovf = 1'b1;
               v = 65535;
            end
         end
         dec_acc = v;
         dec_started = 1'b1;
         return;
      end
      if (b == CHAR_HASH) dec_comment = 1'b1;
      if (!dec_started) return;
      v = dec_acc;
      ovf = dec_ovf;
      dec_acc = 0;
      dec_ovf = 1'b0;
      dec_started = 1'b0;
      end_number(v, ovf);
   endfunction

   // Stimulus builders.
   function automatic void add_byte(logic [7:0] b, logic nf = 1'b0);
      file_byte_type fb;
      fb.in_byte = b;
      fb.new_file = nf;
      pending_bytes.push_back(fb);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_number(int unsigned n);
      add_text($sformatf("%0d", n));
   endfunction

   function automatic logic [7:0] separator();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return CHAR_LF;
         2: return 8'h09;
         default: return 8'h0D;
      endcase
   endfunction

   // A well-formed file with random content; optional comments in the header.
   function automatic void add_file(int fmt, int unsigned w, int unsigned h,
                                    int unsigned maxval);
      int unsigned samples;
      add_byte(CHAR_P, 1'b1);
      add_byte(fmt == 0 ? CHAR_TWO : fmt == 1 ? CHAR_THREE : fmt == 2 ? CHAR_FIVE : CHAR_SIX);
      add_byte(separator());
      if ($urandom_range(0, 3) == 0) add_text("# note\n");
      add_number(w);
      add_byte(separator());
      add_number(h);
      if ($urandom_range(0, 4) == 0) add_text("#x 7\n");
      else add_byte(separator());
      add_number(maxval);
      add_byte(separator());
      samples = w * h * ((fmt % 2) ? 3 : 1);
      for (int unsigned i = 0; i < samples; i++) begin
         if (fmt >= 2) begin
            add_byte(8'($urandom_range(0, 255)));
         end else begin
            add_number($urandom_range(0, 9) == 0 ? $urandom_range(0, 99999)
                                                  : $urandom_range(0, 255));
            add_byte(separator());
         end
      end
   endfunction

   // Acceptance seen at the rising edge, used by the driver at the next falling edge.
   always @(posedge clock) begin
      if (reset) req_taken <= 1'b0;
      else req_taken <= req_valid && req_ready;
   end

   // Driver: bursts of items separated by random gaps, changing on the falling edge.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_in_byte <= 8'd0;
         req_new_file <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            {req_in_byte, req_new_file} <= pending_bytes.pop_front();
            if (burst_left <= 0) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern plus one long hold while the sender keeps going.
   int stall_phase;
   int hold_cycles;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_phase <= 0;
         hold_cycles <= 0;
      end else if (long_hold && hold_cycles < 300) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         stall_phase <= stall_phase + 1;
         if ((stall_phase / 64) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
      end
   end

   // Monitor: predicts on each accepted byte and checks each accepted result.
   always @(posedge clock) begin
      decoded_type got, want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) begin
            decode_byte({req_in_byte, req_new_file});
            byte_count <= byte_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_error_code, rsp_block_row, rsp_block_col, rsp_position,
                   rsp_comp_one, rsp_comp_two, rsp_comp_three, rsp_is_color,
                   rsp_width_out, rsp_height_out, rsp_last};
            result_count <= result_count + 1;
            if (got.kind == KIND_HEADER) header_count <= header_count + 1;
            if (got.kind == KIND_ERROR) error_count <= error_count + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected result item, kind %0d", got.kind);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (got.kind != want.kind)
                     $error("kind: expected %0d got %0d", want.kind, got.kind);
                  if (got.error_code != want.error_code)
                     $error("error_code: expected %0d got %0d",
                            want.error_code, got.error_code);
                  if (got.block_row != want.block_row)
                     $error("block_row: expected %0d got %0d", want.block_row, got.block_row);
                  if (got.block_col != want.block_col)
                     $error("block_col: expected %0d got %0d", want.block_col, got.block_col);
                  if (got.position != want.position)
                     $error("position: expected %0d got %0d", want.position, got.position);
                  if (got.comp_one != want.comp_one)
                     $error("comp_one: expected %0d got %0d", want.comp_one, got.comp_one);
                  if (got.comp_two != want.comp_two)
                     $error("comp_two: expected %0d got %0d", want.comp_two, got.comp_two);
                  if (got.comp_three != want.comp_three)
                     $error("comp_three: expected %0d got %0d",
                            want.comp_three, got.comp_three);
                  if (got.is_color != want.is_color)
                     $error("is_color: expected %0d got %0d", want.is_color, got.is_color);
                  if (got.width_out != want.width_out)
                     $error("width_out: expected %0d got %0d", want.width_out, got.width_out);
                  if (got.height_out != want.height_out)
                     $error("height_out: expected %0d got %0d",
                            want.height_out, got.height_out);
                  if (got.last != want.last)
                     $error("last: expected %0d got %0d", want.last, got.last);
               end
            end
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out with %0d results outstanding", expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int fmt;
      int total_items;
      clear_decoder();
      mismatch_count = 0;
      byte_count = 0;
      result_count = 0;
      header_count = 0;
      error_count = 0;
      cycle_count = 0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'd0;
      req_new_file = 1'b0;
      rsp_ready = 1'b0;

      // Directed: stray bytes, bad magic, bad type, zero and oversized header
      // values, a comment right after a number, a large maxval and a full padded file.
      add_byte(8'hFF);
      add_byte(8'h00, 1'b1);
      add_byte(CHAR_P, 1'b1);
      add_byte(8'h34);
      add_text("7");
      add_byte(CHAR_P, 1'b1);
      add_text("5 0 ");
      add_byte(CHAR_P, 1'b1);
      add_text("2 4097 ");
      add_byte(CHAR_P, 1'b1);
      add_text("2 1 99999999 ");
      add_byte(CHAR_P, 1'b1);
      add_text("2 1 1 0 ");
      add_byte(CHAR_P, 1'b1);
      add_text("3 1#c\n1 1000#z\n");
      add_text("1 2 3 ");
      add_file(2, 1, 1, 255);
      add_byte(8'h41);
      add_file(1, 9, 2, 1);
      add_file(3, 2, 1, 300);
      add_byte(CHAR_P, 1'b1);
      add_text("5 4096 4096 255\n");
      add_byte(8'hFF);
      add_byte(8'h00);

      // Random files, mostly small; a few broken or cut short by a new file.
      while (pending_bytes.size() < 400) begin
         fmt = $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) begin
            add_byte(8'($urandom_range(0, 255)), 1'b1);
            add_byte(8'($urandom_range(0, 255)));
            add_byte(8'($urandom_range(0, 255)));
         end else begin
            add_file(fmt, $urandom_range(1, 9), $urandom_range(1, 3),
                     $urandom_range(0, 5) == 0 ? $urandom_range(1, 65535)
                                               : $urandom_range(1, 255));
            if ($urandom_range(0, 7) == 0) add_text("99 7 ");
         end
      end
      total_items = pending_bytes.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The long receiver hold runs once, partway through the stream.
      wait (pending_bytes.size() < 200);
      long_hold = 1'b1;

      wait (byte_count == total_items);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected_results.size() > 0) mismatch_count++;
      $display("Covered %0d file bytes giving %0d results (%0d headers, %0d errors)",
               byte_count, result_count, header_count, error_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/pnm_pkg.sv
sv/pnm_ctrl.sv
sv/pnm_dpath.sv
sv/pnm_reader_block_padder.sv
tb/sv/pnm_reader_block_padder_test.sv
